FILE: sv/aacp_pkg.sv
// Shared types, constants and fixed-point helpers for the axis angle command parser.
// Used by every module of the parser; depends on nothing else.
package aacp_pkg;

   // Default for the number of fraction digits kept, and its upper limit
   localparam int FRACTION_DIGITS_DEFAULT = 3;
   localparam int FRAC_MAX                = 6;

   // Depth of the byte queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Value range and datapath widths
   localparam int VALUE_LIMIT = 1000000;
   localparam int ACC_CAP     = 1000001;
   localparam int ACC_W       = 20;
   localparam int ACC_STEP_W  = 24;
   localparam int MAG_W       = 20;
   localparam int Z_W         = 21;
   localparam int SCALE_W     = 3;
   localparam int DIGIT_W     = 4;

   // ASCII codes the parser reacts to
   localparam logic [7:0] CHAR_Z     = 8'h5A;
   localparam logic [7:0] CHAR_X     = 8'h58;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      CHR_DIGIT,
      CHR_MINUS,
      CHR_POINT,
      CHR_X,
      CHR_Z,
      CHR_OTHER
   } chr_class_type;

   typedef enum logic [1:0] {
      FIELD_NONE,
      FIELD_Z,
      FIELD_X
   } field_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       is_last;
   } aacp_req_type;

   typedef struct packed {
      logic signed [Z_W-1:0] z_value;
      logic                  z_valid;
      logic [MAG_W-1:0]      x_value;
      logic                  x_valid;
      logic                  parse_error;
   } aacp_rsp_type;

   // Classified byte, as it travels through the queue
   typedef struct packed {
      chr_class_type        cls;
      logic [DIGIT_W-1:0]   digit;
      logic                 is_last;
   } aacp_token_type;

   // Parser state captured on the last byte of a command
   typedef struct packed {
      logic                  err;
      field_type             field;
      logic [ACC_W-1:0]      acc;
      logic [SCALE_W-1:0]    scale;
      logic                  neg;
      logic signed [Z_W-1:0] held_z;
   } aacp_snap_type;

   // Power of ten for the missing fraction digits
   function automatic logic [MAG_W-1:0] pow_ten(input logic [SCALE_W-1:0] k);
      logic [MAG_W-1:0] p;
      case (k)
         3'd0:    p = MAG_W'(1);
         3'd1:    p = MAG_W'(10);
         3'd2:    p = MAG_W'(100);
         3'd3:    p = MAG_W'(1000);
         3'd4:    p = MAG_W'(10000);
         3'd5:    p = MAG_W'(100000);
         3'd6:    p = MAG_W'(1000000);
         default: p = MAG_W'(1);
      endcase
      return p;
   endfunction

   // Largest accumulator value that stays within the limit after scaling
   function automatic logic [MAG_W-1:0] limit_quot(input logic [SCALE_W-1:0] k);
      logic [MAG_W-1:0] q;
      case (k)
         3'd0:    q = MAG_W'(1000000);
         3'd1:    q = MAG_W'(100000);
         3'd2:    q = MAG_W'(10000);
         3'd3:    q = MAG_W'(1000);
         3'd4:    q = MAG_W'(100);
         3'd5:    q = MAG_W'(10);
         3'd6:    q = MAG_W'(1);
         default: q = MAG_W'(1000000);
      endcase
      return q;
   endfunction

   // Scale the accumulator to output units (thousandths by default); saturate at limit
   function automatic logic [MAG_W-1:0] field_mag(input logic [ACC_W-1:0] acc,
                                                  input logic [SCALE_W-1:0] k);
      logic [ACC_W+MAG_W-1:0] prod;
      logic [MAG_W-1:0]       mag;
      prod = acc * pow_ten(k);
      if (MAG_W'(acc) > limit_quot(k)) begin
         mag = MAG_W'(VALUE_LIMIT);
      end else begin
         mag = prod[MAG_W-1:0];
      end
      return mag;
   endfunction

   // Apply the sign to a magnitude
   function automatic logic signed [Z_W-1:0] apply_sign(input logic [MAG_W-1:0] mag,
                                                       input logic neg);
      logic signed [Z_W-1:0] m;
      m = signed'({1'b0, mag});
      return neg ? -m : m;
   endfunction

endpackage

FILE: sv/axis_angle_command_parser_core.sv
// Axis angle command parser, top level.
// Takes an ASCII command such as Z-12.5X30.25 one byte per beat and returns, on
// the last byte, a signed Z and an optional unsigned X, in thousandths by default.
// Input channel: req_data beats are taken at an edge with push high and full low.
// A small front end classifies each byte and writes it to a short queue; the
// parser core drains the queue at one byte per cycle unless a last byte waits.
// Result channel: the oldest result sits on rsp_data while empty is low and
// is taken at an edge with pop high. Only bytes marked last produce a result.
// Throughput: one byte per cycle while the finish stage has room, set by the
// combinational multiply-by-ten accumulate in the parser core.
// Path: a last byte goes from the queue through the snapshot register of the
// finish stage, is scaled there, and lands in the result register (empty low).
// Stall: while the result register and the scaling stage are both occupied and
// no result is popped, a last byte waits at the head of the queue and holds
// back the bytes behind it; full rises only when the queue fills.
// Reset: synchronous; clears the queue, the parser state and both result
// stages, leaving the parser waiting for a leading Z.
// Depends on aacp_pkg, aacp_front, aacp_queue, aacp_exec, aacp_finish.
module axis_angle_command_parser_core #(
   parameter int FRACTION_DIGITS = aacp_pkg::FRACTION_DIGITS_DEFAULT,
   parameter int QUEUE_DEPTH     = aacp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  aacp_pkg::aacp_req_type req_data,
   output logic                   empty,
   input  logic                   pop,
   output aacp_pkg::aacp_rsp_type rsp_data
);
   import aacp_pkg::*;

   aacp_token_type wr_tok, rd_tok;
   logic           tok_valid, tok_take;
   logic           snap_valid, snap_ready;
   aacp_snap_type  snap;

   // Classify incoming bytes
   aacp_front u_front (
      .req_data (req_data),
      .token    (wr_tok)
   );

   // Decouple byte intake from the parser core
   aacp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push),
      .wr_full  (full),
      .wr_data  (wr_tok),
      .rd_valid (tok_valid),
      .rd_take  (tok_take),
      .rd_data  (rd_tok)
   );

   // Walk the command
   aacp_exec #(
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_exec (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (tok_valid),
      .tok_take   (tok_take),
      .tok        (rd_tok),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   // Scale and hold results
   aacp_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .pop        (pop),
      .empty      (empty),
      .rsp_data   (rsp_data)
   );

   // An error result carries no valid angle
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.parse_error) |-> (!rsp_data.z_valid && !rsp_data.x_valid))
      else $error("error result marked valid");

   // X is only valid together with Z
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.x_valid) |-> rsp_data.z_valid)
      else $error("x_valid without z_valid");

   // Z stays within the saturation limits
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.z_value <= Z_W'(VALUE_LIMIT)
                  && rsp_data.z_value >= -Z_W'(VALUE_LIMIT)))
      else $error("z_value out of range");

   // X stays within the saturation limit
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.x_value <= MAG_W'(VALUE_LIMIT)))
      else $error("x_value out of range");

endmodule

FILE: sv/aacp_front.sv
// Front end of the angle command parser: classifies each received byte.
// Depends on aacp_pkg.
module aacp_front (
   input  aacp_pkg::aacp_req_type   req_data,
   output aacp_pkg::aacp_token_type token
);
   import aacp_pkg::*;

   // Sort the byte into the classes the parser acts on
   always_comb begin
      token.is_last = req_data.is_last;
      token.digit   = DIGIT_W'(req_data.char_in - CHAR_ZERO);
      if (req_data.char_in inside {[CHAR_ZERO:CHAR_NINE]}) begin
         token.cls = CHR_DIGIT;
      end else begin
         case (req_data.char_in)
            CHAR_MINUS: token.cls = CHR_MINUS;
            CHAR_POINT: token.cls = CHR_POINT;
            CHAR_X:     token.cls = CHR_X;
            CHAR_Z:     token.cls = CHR_Z;
            default:    token.cls = CHR_OTHER;
         endcase
      end
   end

endmodule

FILE: sv/aacp_queue.sv
// Short queue of classified bytes between the front end and the parser core.
// Depends on aacp_pkg.
module aacp_queue #(
   parameter int DEPTH = aacp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_valid,
   output logic                     wr_full,
   input  aacp_pkg::aacp_token_type wr_data,
   output logic                     rd_valid,
   input  logic                     rd_take,
   output aacp_pkg::aacp_token_type rd_data
);
   import aacp_pkg::*;

   localparam int PtrW = (DEPTH < 2) ? 1 : $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   aacp_token_type      slot_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                push_ok, pop_ok;

   assign wr_full  = (count_ff == CntW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign push_ok  = wr_valid && !wr_full;
   assign pop_ok   = rd_take && rd_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming beat
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: sv/aacp_exec.sv
// Parser core: walks the command one classified byte a cycle, holding a last
// byte for finish room, then hands off a state snapshot. Depends on aacp_pkg.
module aacp_exec #(
   parameter int FRACTION_DIGITS = aacp_pkg::FRACTION_DIGITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     tok_valid,
   output logic                     tok_take,
   input  aacp_pkg::aacp_token_type tok,
   output logic                     snap_valid,
   input  logic                     snap_ready,
   output aacp_pkg::aacp_snap_type  snap
);
   import aacp_pkg::*;

   localparam int FracUsed = (FRACTION_DIGITS > FRAC_MAX) ? FRAC_MAX : FRACTION_DIGITS;
   localparam int FracW    = (FracUsed < 1) ? 1 : $clog2(FracUsed + 1);

   logic                  at_start_ff, at_start_in;
   field_type             field_ff, field_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic                  point_ff, point_in;
   logic [FracW-1:0]      frac_ff, frac_in;
   logic signed [Z_W-1:0] held_z_ff, held_z_in;
   logic                  err_ff, err_in;
   logic [ACC_STEP_W-1:0] acc_wide;
   logic [ACC_W-1:0]      acc_step;
   logic signed [Z_W-1:0] z_now;

   // Hold a last byte until the finish stage has room
   assign tok_take   = tok_valid && (!tok.is_last || snap_ready);
   assign snap_valid = tok_valid && tok.is_last;

   // Multiply-by-ten accumulate, saturated just above the limit
   always_comb begin
      acc_wide = (ACC_STEP_W'(acc_ff) << 3) + (ACC_STEP_W'(acc_ff) << 1)
               + ACC_STEP_W'(tok.digit);
      acc_step = (acc_wide > ACC_STEP_W'(ACC_CAP)) ? ACC_W'(ACC_CAP) : acc_wide[ACC_W-1:0];
   end

   // Signed Z value of the field closed by an X
   assign z_now = apply_sign(field_mag(acc_ff, SCALE_W'(FracUsed) - SCALE_W'(frac_ff)),
                             neg_ff);

   always_comb begin
      at_start_in = at_start_ff;
      field_in    = field_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      point_in    = point_ff;
      frac_in     = frac_ff;
      held_z_in   = held_z_ff;
      err_in      = err_ff;
      if (tok_valid && !err_ff) begin
         if (field_ff == FIELD_NONE) begin
            // Command must open with Z
            if (tok.cls == CHR_Z) begin
               field_in    = FIELD_Z;
               at_start_in = 1'b1;
            end else begin
               err_in = 1'b1;
            end
         end else begin
            at_start_in = 1'b0;
            case (tok.cls)
               CHR_DIGIT: begin
                  if (!point_ff) begin
                     acc_in = acc_step;
                  end else if (frac_ff < FracW'(FracUsed)) begin
                     acc_in  = acc_step;
                     frac_in = frac_ff + 1'b1;
                  end
               end
               CHR_MINUS: begin
                  if (field_ff == FIELD_Z && at_start_ff) begin
                     neg_in = 1'b1;
                  end else begin
                     err_in = 1'b1;
                  end
               end
               CHR_POINT: begin
                  if (point_ff) begin
                     err_in = 1'b1;
                  end else begin
                     point_in = 1'b1;
                  end
               end
               CHR_X: begin
                  // Close the Z field and start the X field
                  if (field_ff == FIELD_Z) begin
                     held_z_in = z_now;
                     acc_in    = '0;
                     neg_in    = 1'b0;
                     point_in  = 1'b0;
                     frac_in   = '0;
                     field_in  = FIELD_X;
                  end else begin
                     err_in = 1'b1;
                  end
               end
               default: err_in = 1'b1;
            endcase
         end
      end

      // Capture the finished command
      snap.err    = err_in || (field_in == FIELD_NONE);
      snap.field  = field_in;
      snap.acc    = acc_in;
      snap.scale  = SCALE_W'(FracUsed) - SCALE_W'(frac_in);
      snap.neg    = neg_in;
      snap.held_z = held_z_in;

      // Clear everything once the last byte has gone through
      if (tok_take && tok.is_last) begin
         at_start_in = 1'b1;
         field_in    = FIELD_NONE;
         acc_in      = '0;
         neg_in      = 1'b0;
         point_in    = 1'b0;
         frac_in     = '0;
         held_z_in   = '0;
         err_in      = 1'b0;
      end
   end

   // Advance only on a consumed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         field_ff    <= FIELD_NONE;
         acc_ff      <= '0;
         neg_ff      <= 1'b0;
         point_ff    <= 1'b0;
         frac_ff     <= '0;
         held_z_ff   <= '0;
         err_ff      <= 1'b0;
      end else if (tok_take) begin
         at_start_ff <= at_start_in;
         field_ff    <= field_in;
         acc_ff      <= acc_in;
         neg_ff      <= neg_in;
         point_ff    <= point_in;
         frac_ff     <= frac_in;
         held_z_ff   <= held_z_in;
         err_ff      <= err_in;
      end
   end

endmodule

FILE: sv/aacp_finish.sv
// Finish stage: scales the captured field to output units (thousandths by
// default) and holds the result until it is popped. Depends on aacp_pkg.
module aacp_finish (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    snap_valid,
   output logic                    snap_ready,
   input  aacp_pkg::aacp_snap_type snap,
   input  logic                    pop,
   output logic                    empty,
   output aacp_pkg::aacp_rsp_type  rsp_data
);
   import aacp_pkg::*;

   logic             fin_valid_ff, fin_valid_in;
   aacp_snap_type    fin_ff;
   logic             out_valid_ff, out_valid_in;
   aacp_rsp_type     out_ff, out_in;
   logic             move, rsp_take, snap_take;
   logic [MAG_W-1:0] mag;

   assign rsp_take   = pop && out_valid_ff;
   assign move       = fin_valid_ff && (!out_valid_ff || rsp_take);
   assign snap_ready = !fin_valid_ff || move;
   assign snap_take  = snap_valid && snap_ready;
   assign empty      = !out_valid_ff;
   assign rsp_data   = out_ff;

   assign mag = field_mag(fin_ff.acc, fin_ff.scale);

   // Build the result from the captured state
   always_comb begin
      out_in = '0;
      if (!fin_ff.err) begin
         out_in.z_valid = 1'b1;
         if (fin_ff.field == FIELD_X) begin
            out_in.z_value = fin_ff.held_z;
            out_in.x_value = mag;
            out_in.x_valid = 1'b1;
         end else begin
            out_in.z_value = apply_sign(mag, fin_ff.neg);
         end
      end else begin
         out_in.parse_error = 1'b1;
      end
   end

   always_comb begin
      fin_valid_in = (fin_valid_ff && !move) || snap_take;
      out_valid_in = (out_valid_ff && !rsp_take) || move;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Load payload registers on their handshakes
   always_ff @(posedge clock) begin
      if (snap_take) begin
         fin_ff <= snap;
      end
      if (move) begin
         out_ff <= out_in;
      end
   end

endmodule
